// ===== src/ils_pkg.sv =====
// Package: shared types, codes and defaults for the indexed list store.
package ils_pkg;

    localparam int unsigned CapacityDefault  = 16;
    localparam int unsigned DataWidthDefault = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_READ       = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        AT_ZERO  = 2'd0,
        AT_COUNT = 2'd1,
        AT_LAST  = 2'd2,
        AT_POS   = 2'd3
    } at_sel_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [4:0]  position;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  count;
        logic        front_valid;
        logic [31:0] front_value;
        logic [31:0] read_value;
    } out_item_t;

    typedef struct packed {
        logic    exec;
        action_t action;
        at_sel_t at_sel;
        logic    rd_en;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_le_count;
        logic pos_lt_count;
    } dp_flags_t;

endpackage

// ===== src/ils_ctrl.sv =====
// Controller: transfer handshake, result-pending state and opcode decode.
module ils_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ils_pkg::opcode_t   opcode,
    output logic               m_valid,
    input  logic               m_ready,
    input  ils_pkg::dp_flags_t flags,
    output ils_pkg::dp_cmd_t   cmd
);
    import ils_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic    exec;
    action_t action;
    at_sel_t at_sel;
    logic    rd_en;
    status_t status;

    assign s_ready = (state_reg == ST_IDLE) || m_ready;
    assign m_valid = (state_reg == ST_HOLD);
    assign exec    = s_valid && s_ready;

    always_comb begin
        action = ACT_NONE;
        at_sel = AT_ZERO;
        rd_en  = 1'b0;
        status = STATUS_OK;
        case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (flags.full) begin
                    status = STATUS_FULL;
                end else begin
                    action = ACT_INSERT;
                    at_sel = (opcode == OP_PUSH_FRONT) ? AT_ZERO : AT_COUNT;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (flags.empty) begin
                    status = STATUS_EMPTY;
                end else begin
                    action = ACT_REMOVE;
                    at_sel = (opcode == OP_POP_FRONT) ? AT_ZERO : AT_LAST;
                end
            end
            OP_INSERT: begin
                if (!flags.pos_le_count) begin
                    status = STATUS_RANGE;
                end else if (flags.full) begin
                    status = STATUS_FULL;
                end else begin
                    action = ACT_INSERT;
                    at_sel = AT_POS;
                end
            end
            OP_ERASE: begin
                if (!flags.pos_lt_count) begin
                    status = STATUS_RANGE;
                end else begin
                    action = ACT_REMOVE;
                    at_sel = AT_POS;
                end
            end
            OP_CLEAR: begin
                action = ACT_CLEAR;
            end
            OP_READ: begin
                if (!flags.pos_lt_count) begin
                    status = STATUS_RANGE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            default: begin
                action = ACT_NONE;
            end
        endcase
    end

    assign cmd = '{exec: exec, action: action, at_sel: at_sel, rd_en: rd_en, status: status};

    always_comb begin
        state_next = state_reg;
        if (exec) begin
            state_next = ST_HOLD;
        end else if (m_ready) begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/ils_datapath.sv =====
// Datapath: shifting element cells, element count and result register.
module ils_datapath #(
    parameter int unsigned CAPACITY   = ils_pkg::CapacityDefault,
    parameter int unsigned DATA_WIDTH = ils_pkg::DataWidthDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ils_pkg::in_item_t  in_item,
    input  ils_pkg::dp_cmd_t   cmd,
    output ils_pkg::dp_flags_t flags,
    output ils_pkg::out_item_t out_item
);
    import ils_pkg::*;

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

    logic [DATA_WIDTH-1:0] cells_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] cells_next [CAPACITY];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    out_item_t             result_reg;
    out_item_t             result_next;

    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [IDX_W-1:0]      pos_idx;
    logic [IDX_W-1:0]      at_idx;
    logic [CNT_W-1:0]      last_cnt;
    logic [DATA_WIDTH-1:0] wr_value;
    logic [DATA_WIDTH-1:0] rd_word;

    assign pos_ext  = CMP_W'(in_item.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_idx  = pos_ext[IDX_W-1:0];
    assign last_cnt = count_reg - CNT_W'(1);
    assign wr_value = DATA_WIDTH'(in_item.value);
    assign rd_word  = cells_reg[pos_idx];

    assign flags = '{
        full:         (count_reg == CNT_W'(CAPACITY)),
        empty:        (count_reg == '0),
        pos_le_count: (pos_ext <= cnt_ext),
        pos_lt_count: (pos_ext < cnt_ext)
    };

    always_comb begin
        case (cmd.at_sel)
            AT_ZERO:  at_idx = '0;
            AT_COUNT: at_idx = IDX_W'(count_reg);
            AT_LAST:  at_idx = IDX_W'(last_cnt);
            AT_POS:   at_idx = pos_idx;
            default:  at_idx = '0;
        endcase
    end

    always_comb begin
        cells_next = cells_reg;
        count_next = count_reg;
        if (cmd.exec) begin
            case (cmd.action)
                ACT_INSERT: begin
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (IDX_W'(i) > at_idx) begin
                            cells_next[i] = cells_reg[i-1];
                        end
                    end
                    cells_next[at_idx] = wr_value;
                    count_next = count_reg + CNT_W'(1);
                end
                ACT_REMOVE: begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (IDX_W'(i) >= at_idx) begin
                            cells_next[i] = cells_reg[i+1];
                        end
                    end
                    count_next = last_cnt;
                end
                ACT_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_comb begin
        result_next.status      = cmd.status;
        result_next.count       = 5'(count_next);
        result_next.front_valid = (count_next != '0);
        result_next.front_value = (count_next != '0) ? 32'(cells_next[0]) : 32'd0;
        result_next.read_value  = cmd.rd_en ? 32'(rd_word) : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cells_reg <= cells_next;
        if (cmd.exec) begin
            result_reg <= result_next;
        end
    end

    assign out_item = result_reg;

endmodule

// ===== src/indexed_list_store.sv =====
// Top level: indexed list store, controller plus datapath.
//
// An ordered list of up to CAPACITY words of DATA_WIDTH bits, packed from
// index 0. Requests arrive on the s_ channel (opcode, position, value) and
// each request gives exactly one result on the m_ channel (status, count,
// front element, element read), in request order.
// Latency: a request's result is presented in the cycle after its transfer.
// Throughput: one request per cycle while m_ready is high. Each cell picks
// shift up, shift down, load or hold from a compare against the operation
// index, so a whole insert or erase completes in the transfer cycle.
// The result register is the only buffer: while a result waits, a new
// request is taken only in a cycle where that result is taken too, so a
// stalled receiver stalls the sender with s_ready low.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; cell contents are not cleared and are never read before written.
module indexed_list_store #(
    parameter int unsigned CAPACITY   = ils_pkg::CapacityDefault,
    parameter int unsigned DATA_WIDTH = ils_pkg::DataWidthDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ils_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ils_pkg::out_item_t m_data
);
    import ils_pkg::*;

    dp_cmd_t   cmd;
    dp_flags_t flags;

    ils_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_data.opcode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    ils_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_data),
        .cmd      (cmd),
        .flags    (flags),
        .out_item (m_data)
    );

endmodule

// ===== src/ils_checker.sv =====
// Checker: port-level properties of the indexed list store, bound to the top level.
module ils_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input ils_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input ils_pkg::out_item_t m_data
);
    import ils_pkg::*;

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("no result after request transfer");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("pending result dropped or changed");

    a_empty_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.front_valid) |-> (m_data.count == '0 && m_data.front_value == '0))
        else $error("empty list shows a count or front element");

    a_read_ok_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.read_value != '0) |-> (m_data.status == STATUS_OK))
        else $error("read data on a refused request");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    logic unused_in;
    assign unused_in = ^s_data;

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
